[src/crcfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package crcfr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned PAYLOAD_W   = 32;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned POS_W       = 4;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_HEAD_ONE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAD_TWO = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_ONE = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_TWO = 8'd3;

    localparam logic [BYTE_W-1:0] HEAD_ONE_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] HEAD_TWO_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] TAIL_ONE_RESET = 8'h0D;
    localparam logic [BYTE_W-1:0] TAIL_TWO_RESET = 8'h0A;

    // Byte positions within a frame.
    localparam logic [POS_W-1:0] POS_HEAD_ONE = 4'd0;
    localparam logic [POS_W-1:0] POS_HEAD_TWO = 4'd1;
    localparam logic [POS_W-1:0] POS_COMMAND  = 4'd2;
    localparam logic [POS_W-1:0] POS_PAY0     = 4'd3;
    localparam logic [POS_W-1:0] POS_PAY1     = 4'd4;
    localparam logic [POS_W-1:0] POS_PAY2     = 4'd5;
    localparam logic [POS_W-1:0] POS_PAY3     = 4'd6;
    localparam logic [POS_W-1:0] POS_CRC_HIGH = 4'd7;
    localparam logic [POS_W-1:0] POS_CRC_LOW  = 4'd8;
    localparam logic [POS_W-1:0] POS_TAIL_ONE = 4'd9;
    localparam logic [POS_W-1:0] POS_TAIL_TWO = 4'd10;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_BAD_HEADER,
        STATUS_BAD_TAIL,
        STATUS_BAD_CRC
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] head_one;
        logic [BYTE_W-1:0] head_two;
        logic [BYTE_W-1:0] tail_one;
        logic [BYTE_W-1:0] tail_two;
    } cfg_t;

    typedef struct packed {
        status_t              status;
        logic [BYTE_W-1:0]    command;
        logic [PAYLOAD_W-1:0] payload;
    } result_t;

    // One byte through CRC-16 with polynomial 0x1021, most significant bit first.
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != '0)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[src/crc16_frame_receiver_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial receiver for fixed eleven-byte frames: two header bytes, a command
// byte, four payload bytes (the first is least significant in the payload word), a
// big-endian CRC-16 with polynomial 0x1021 and initial value 0xFFFF, unreflected,
// over the command and payload, and two tail bytes. Framing is by byte count
// alone from reset; there is no search for the header. After the eleventh byte
// one result transaction carries the status (0 ok, 1 bad header, 2 bad tail,
// 3 CRC mismatch, checked in that order) with the command and payload, which
// read as zero whenever the status is not ok. The expected header and tail
// bytes are configuration registers 0 to 3 (reset 0xAA, 0x55, 0x0D, 0x0A);
// writes to other indexes are ignored, and configuration should only be
// written while no frame is in progress. One byte is taken every clock cycle,
// unless the last byte of a frame is held because the result register is full:
// a byte is held in the input register, and the byte-wide CRC update and the
// field checks then run combinationally into the frame state. The output
// register is loaded at the same edge at which the last byte of a frame is
// processed, so the result is offered once that byte has left the input
// register. The receiver keeps taking bytes while that result waits to be
// taken; it stalls only when a further frame completes before the previous result has gone.
module crc16_frame_receiver_core
    import crcfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]      cfg_data,

    input  wire logic                   rx_valid,
    output logic                        rx_ready,
    input  wire logic [BYTE_W-1:0]      rx_byte,

    output logic                        frame_valid,
    input  wire logic                   frame_ready,
    output logic [1:0]                  frame_status,
    output logic [BYTE_W-1:0]           command,
    output logic [PAYLOAD_W-1:0]        payload
);

    cfg_t    cfg;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t frame;

    // Header and tail match values.
    crcfr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register, frame position, running CRC and error flags.
    crcfr_frame_core u_frame_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register that holds a finished frame until it is taken.
    crcfr_result_reg u_result_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    assign frame_status = frame.status;
    assign command      = frame.command;
    assign payload      = frame.payload;

endmodule

`default_nettype wire

[src/crcfr_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module crcfr_cfg_regs
    import crcfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]      cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_HEAD_ONE: cfg_next.head_one = cfg_data;
                REG_HEAD_TWO: cfg_next.head_two = cfg_data;
                REG_TAIL_ONE: cfg_next.tail_one = cfg_data;
                REG_TAIL_TWO: cfg_next.tail_two = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_one <= HEAD_ONE_RESET;
            cfg_reg.head_two <= HEAD_TWO_RESET;
            cfg_reg.tail_one <= TAIL_ONE_RESET;
            cfg_reg.tail_two <= TAIL_TWO_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[src/crcfr_frame_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module crcfr_frame_core
    import crcfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rx_valid,
    output logic                   rx_ready,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire cfg_t              cfg,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res
);

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;

    logic [POS_W-1:0]     pos_reg,          pos_next;
    logic [CRC_W-1:0]     crc_reg,          crc_next;
    logic [BYTE_W-1:0]    command_reg,      command_next;
    logic [PAYLOAD_W-1:0] payload_reg,      payload_next;
    logic [BYTE_W-1:0]    crc_high_reg,     crc_high_next;
    logic                 header_bad_reg,   header_bad_next;
    logic                 crc_bad_reg,      crc_bad_next;
    logic                 tail_bad_reg,     tail_bad_next;

    logic [POS_W-1:0]     pos_eff;
    logic [1:0]           lane;
    logic                 last_byte;
    logic                 step_fire;
    logic                 tail_bad_final;

    // A position beyond the last one is taken as the start of a frame.
    assign pos_eff   = (pos_reg > POS_TAIL_TWO) ? POS_HEAD_ONE : pos_reg;
    assign last_byte = (pos_eff == POS_TAIL_TWO);
    assign lane      = 2'(pos_eff - POS_PAY0);

    // The byte held in the input register is consumed unless it closes a frame
    // and the result register cannot take the result.
    assign step_fire = in_valid_reg && (!last_byte || res_ready);
    assign rx_ready  = !in_valid_reg || step_fire;
    assign res_valid = in_valid_reg && last_byte;

    assign tail_bad_final = tail_bad_reg || (in_byte_reg != cfg.tail_two);

    always_comb
    begin
        if (header_bad_reg)
        begin
            res.status = STATUS_BAD_HEADER;
        end
        else if (tail_bad_final)
        begin
            res.status = STATUS_BAD_TAIL;
        end
        else if (crc_bad_reg)
        begin
            res.status = STATUS_BAD_CRC;
        end
        else
        begin
            res.status = STATUS_OK;
        end
        res.command = (res.status == STATUS_OK) ? command_reg : '0;
        res.payload = (res.status == STATUS_OK) ? payload_reg : '0;
    end

    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        command_next    = command_reg;
        payload_next    = payload_reg;
        crc_high_next   = crc_high_reg;
        header_bad_next = header_bad_reg;
        crc_bad_next    = crc_bad_reg;
        tail_bad_next   = tail_bad_reg;
        if (step_fire)
        begin
            pos_next = last_byte ? POS_HEAD_ONE : pos_eff + 4'd1;
            case (pos_eff)
                POS_HEAD_ONE:
                begin
                    crc_next        = CRC_INIT;
                    crc_bad_next    = 1'b0;
                    tail_bad_next   = 1'b0;
                    header_bad_next = (in_byte_reg != cfg.head_one);
                end
                POS_HEAD_TWO:
                begin
                    header_bad_next = header_bad_reg || (in_byte_reg != cfg.head_two);
                end
                POS_COMMAND:
                begin
                    command_next = in_byte_reg;
                    crc_next     = crc_feed(crc_reg, in_byte_reg);
                end
                POS_PAY0, POS_PAY1, POS_PAY2, POS_PAY3:
                begin
                    payload_next[BYTE_W*lane +: BYTE_W] = in_byte_reg;
                    crc_next = crc_feed(crc_reg, in_byte_reg);
                end
                POS_CRC_HIGH:
                begin
                    crc_high_next = in_byte_reg;
                end
                POS_CRC_LOW:
                begin
                    crc_bad_next = ({crc_high_reg, in_byte_reg} != crc_reg);
                end
                POS_TAIL_ONE:
                begin
                    tail_bad_next = (in_byte_reg != cfg.tail_one);
                end
                default:
                begin
                    tail_bad_next = tail_bad_final;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            pos_reg        <= POS_HEAD_ONE;
            crc_reg        <= CRC_INIT;
            command_reg    <= '0;
            payload_reg    <= '0;
            crc_high_reg   <= '0;
            header_bad_reg <= 1'b0;
            crc_bad_reg    <= 1'b0;
            tail_bad_reg   <= 1'b0;
        end
        else
        begin
            if (rx_ready)
            begin
                in_valid_reg <= rx_valid;
            end
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            command_reg    <= command_next;
            payload_reg    <= payload_next;
            crc_high_reg   <= crc_high_next;
            header_bad_reg <= header_bad_next;
            crc_bad_reg    <= crc_bad_next;
            tail_bad_reg   <= tail_bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

[src/crcfr_result_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module crcfr_result_reg
    import crcfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    output logic         res_ready,
    input  wire result_t res,
    output logic         frame_valid,
    input  wire logic    frame_ready,
    output result_t      frame
);

    logic    out_valid_reg;
    result_t out_data_reg;

    // The register is free when empty or when its contents leave this cycle.
    assign res_ready   = !out_valid_reg || frame_ready;
    assign frame_valid = out_valid_reg;
    assign frame       = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

endmodule

`default_nettype wire
